### src/ball_pair_elastic_collision_core_macros.svh
// assertion macros for the elastic collision core
// used by the top level only; expects clk and rst_n in scope
`ifndef BALL_PAIR_ELASTIC_COLLISION_CORE_MACROS_SVH
`define BALL_PAIR_ELASTIC_COLLISION_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BPEC_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("bpec: same-cycle check failed");
`define BPEC_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("bpec: next-cycle check failed");
`else
`define BPEC_ASSERT_IMPL(lbl, a, b)
`define BPEC_ASSERT_NEXT(lbl, a, b)
`endif
`endif

### src/bpec_pkg.sv
// types, widths and helpers shared by the elastic collision core
// no dependencies
package bpec_pkg;

  localparam int POS_W    = 12;
  localparam int VEL_W    = 32;
  localparam int MASS_W   = 16;
  localparam int RAD_W    = 10;
  localparam int DIFF_W   = POS_W + 1;
  localparam int SQ_W     = 2 * POS_W;
  localparam int D2_W     = SQ_W + 1;
  localparam int RS_W     = RAD_W + 1;
  localparam int RS2_W    = 2 * RS_W;
  localparam int DV_W     = VEL_W + 1;
  localparam int PP_W     = DV_W + DIFF_W;
  localparam int P_W      = PP_W + 1;
  localparam int N_W      = P_W + DIFF_W - 1;
  localparam int NMAG_W   = N_W - 1;
  localparam int Q1_W     = 34;
  localparam int A_W      = Q1_W;
  localparam int K_W      = MASS_W + 1;
  localparam int MSUM_W   = MASS_W + 1;
  localparam int AK_W     = A_W + K_W;
  localparam int AKMAG_W  = AK_W - 1;
  localparam int Q2_W     = 34;
  localparam int C_W      = Q2_W + 1;
  localparam int SUM_W    = C_W + 1;
  localparam int D1_LANES = 2;
  localparam int D2_LANES = 4;

  typedef struct packed {
    logic [POS_W-1:0]         first_pos_x;
    logic [POS_W-1:0]         first_pos_y;
    logic [POS_W-1:0]         second_pos_x;
    logic [POS_W-1:0]         second_pos_y;
    logic signed [VEL_W-1:0]  first_vel_x;
    logic signed [VEL_W-1:0]  first_vel_y;
    logic signed [VEL_W-1:0]  second_vel_x;
    logic signed [VEL_W-1:0]  second_vel_y;
    logic [MASS_W-1:0]        first_mass;
    logic [MASS_W-1:0]        second_mass;
    logic [RAD_W-1:0]         first_radius;
    logic [RAD_W-1:0]         second_radius;
  } in_item_t;

  typedef struct packed {
    logic                     collided;
    logic                     coincident;
    logic signed [VEL_W-1:0]  new_first_vel_x;
    logic signed [VEL_W-1:0]  new_first_vel_y;
    logic signed [VEL_W-1:0]  new_second_vel_x;
    logic signed [VEL_W-1:0]  new_second_vel_y;
  } out_item_t;

  // velocities and verdict carried down the back end
  typedef struct packed {
    logic signed [VEL_W-1:0]  v1x;
    logic signed [VEL_W-1:0]  v1y;
    logic signed [VEL_W-1:0]  v2x;
    logic signed [VEL_W-1:0]  v2y;
    logic                     hit;
    logic                     same;
    logic                     apply;
  } base_t;

  // classified pair as queued between front and back
  typedef struct packed {
    base_t                    base;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [D2_W-1:0]          d2;
    logic [MASS_W-1:0]        m1;
    logic [MASS_W-1:0]        m2;
  } pair_t;

  typedef struct packed {
    base_t                    base;
    logic [MASS_W-1:0]        m1;
    logic [MASS_W-1:0]        m2;
    logic                     neg_x;
    logic                     neg_y;
  } d1_side_t;

  typedef struct packed {
    base_t                    base;
    logic [D2_LANES-1:0]      neg;
  } d2_side_t;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-VEL_W:0] top;
    top = v[SUM_W-1:VEL_W-1];
    if (top == '0 || top == '1) begin
      return v[VEL_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VEL_W-1){1'b1}}};
    end
  endfunction

endpackage

### src/bpec_front.sv
// front end: takes a pair, forms the centre difference and overlap verdict
// depends on bpec_pkg; feeds the queue
module bpec_front import bpec_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     push_v,
  output pair_t    push_item,
  input  logic     fifo_full
);

  logic [2:0] v_r;
  logic       en;
  pair_t      f1_pair_r, f2_pair_r, f3_pair_r;
  pair_t      f1_pair_nxt, f3_pair_nxt;
  logic [RS_W-1:0]  f1_rs_r;
  logic [SQ_W-1:0]  f2_dx2_r, f2_dy2_r;
  logic [RS2_W-1:0] f2_rs2_r;
  logic [SQ_W-1:0]  dx2_nxt, dy2_nxt;
  logic [D2_W-1:0]  d2;
  logic signed [2*DIFF_W-1:0] dxx, dyy;

  assign en        = !(v_r[2] && fifo_full);
  assign in_stall  = !en;
  assign push_v    = v_r[2] && !fifo_full;
  assign push_item = f3_pair_r;

  always_comb begin
    f1_pair_nxt            = '0;
    f1_pair_nxt.base.v1x   = in_data.first_vel_x;
    f1_pair_nxt.base.v1y   = in_data.first_vel_y;
    f1_pair_nxt.base.v2x   = in_data.second_vel_x;
    f1_pair_nxt.base.v2y   = in_data.second_vel_y;
    f1_pair_nxt.m1         = in_data.first_mass;
    f1_pair_nxt.m2         = in_data.second_mass;
    f1_pair_nxt.dx = $signed({1'b0, in_data.first_pos_x}) - $signed({1'b0, in_data.second_pos_x});
    f1_pair_nxt.dy = $signed({1'b0, in_data.first_pos_y}) - $signed({1'b0, in_data.second_pos_y});
  end

  always_comb begin
    dxx     = (2*DIFF_W)'(f1_pair_r.dx) * (2*DIFF_W)'(f1_pair_r.dx);
    dyy     = (2*DIFF_W)'(f1_pair_r.dy) * (2*DIFF_W)'(f1_pair_r.dy);
    dx2_nxt = dxx[SQ_W-1:0];
    dy2_nxt = dyy[SQ_W-1:0];
  end

  always_comb begin
    d2                     = D2_W'(f2_dx2_r) + D2_W'(f2_dy2_r);
    f3_pair_nxt            = f2_pair_r;
    f3_pair_nxt.d2         = d2;
    f3_pair_nxt.base.hit   = D2_W'(f2_rs2_r) > d2;
    f3_pair_nxt.base.same  = f3_pair_nxt.base.hit && (d2 == '0);
    // both masses zero leaves velocities alone
    f3_pair_nxt.base.apply = f3_pair_nxt.base.hit && (d2 != '0)
                             && ((f2_pair_r.m1 | f2_pair_r.m2) != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_pair_r <= f1_pair_nxt;
      f1_rs_r   <= RS_W'(in_data.first_radius) + RS_W'(in_data.second_radius);
      f2_pair_r <= f1_pair_r;
      f2_dx2_r  <= dx2_nxt;
      f2_dy2_r  <= dy2_nxt;
      f2_rs2_r  <= RS2_W'(f1_rs_r) * RS2_W'(f1_rs_r);
      f3_pair_r <= f3_pair_nxt;
    end
  end

endmodule

### src/bpec_fifo.sv
// short queue of classified pairs between front and back
// depends on bpec_pkg
module bpec_fifo import bpec_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  pair_t push_item,
  output logic  full,
  input  logic  pop,
  output pair_t head,
  output logic  empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  pair_t          mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  assign full  = cnt_r == CW'(DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### src/bpec_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, lanes share a divisor
// no package use; the caller guarantees the quotient fits in QW bits
module bpec_div_pipe #(
  parameter int LANES = 2,
  parameter int NW    = 58,
  parameter int DW    = 25,
  parameter int QW    = 34,
  parameter int SW    = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_v,
  input  logic [LANES-1:0][NW-1:0]   in_num,
  input  logic [DW-1:0]              in_den,
  input  logic [SW-1:0]              in_side,
  output logic                       out_v,
  output logic [LANES-1:0][QW-1:0]   out_quo,
  output logic [SW-1:0]              out_side
);

  logic [QW:0]                 v_r;
  logic [LANES-1:0][DW-1:0]    rem_r   [QW+1];
  logic [LANES-1:0][QW-1:0]    low_r   [QW+1];
  logic [DW-1:0]               den_r   [QW+1];
  logic [SW-1:0]               side_r  [QW+1];
  logic [LANES-1:0][DW:0]      trial   [QW];
  logic [LANES-1:0]            ge      [QW];
  logic [LANES-1:0][DW-1:0]    rem_nxt [QW];
  logic [LANES-1:0][QW-1:0]    low_nxt [QW];

  // low word shifts out dividend bits and shifts in quotient bits
  always_comb begin
    for (int s = 0; s < QW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        trial[s][l]   = {rem_r[s][l], low_r[s][l][QW-1]};
        ge[s][l]      = trial[s][l] >= {1'b0, den_r[s]};
        rem_nxt[s][l] = ge[s][l] ? DW'(trial[s][l] - {1'b0, den_r[s]})
                                 : trial[s][l][DW-1:0];
        low_nxt[s][l] = {low_r[s][l][QW-2:0], ge[s][l]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l] <= DW'(in_num[l][NW-1:QW]);
        low_r[0][l] <= in_num[l][QW-1:0];
      end
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
      for (int s = 0; s < QW; s++) begin
        rem_r[s+1]  <= rem_nxt[s];
        low_r[s+1]  <= low_nxt[s];
        den_r[s+1]  <= den_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_v    = v_r[QW];
  assign out_quo  = low_r[QW];
  assign out_side = side_r[QW];

endmodule

### src/bpec_back.sv
// back end: projection, two pipelined divides, exchange and saturation
// depends on bpec_pkg and bpec_div_pipe; owns the output register
module bpec_back import bpec_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fifo_empty,
  input  pair_t     head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic en;
  logic b1_v_r, b2_v_r, b3_v_r, b4_v_r, b6_v_r, b7_v_r, b8_v_r, out_v_r;
  pair_t b1_pair_r, b2_pair_r, b3_pair_r, b4_pair_r;
  logic signed [DV_W-1:0] b1_dvx_r, b1_dvy_r;
  logic signed [PP_W-1:0] b2_px_r, b2_py_r;
  logic signed [P_W-1:0]  b3_p_r;
  logic signed [N_W-1:0]  b4_nx_r, b4_ny_r;

  logic [D1_LANES-1:0][NMAG_W-1:0] d1_num;
  logic [D1_LANES-1:0][Q1_W-1:0]   d1_quo;
  d1_side_t d1_in_side, d1_out_side;
  logic     d1_v;

  base_t                 b6_base_r;
  logic [MASS_W-1:0]     b6_m1_r, b6_m2_r;
  logic [MSUM_W-1:0]     b6_msum_r;
  logic signed [A_W-1:0] b6_ax_r, b6_ay_r;
  logic [K_W-1:0]        k1, k2;

  base_t                  b7_base_r;
  logic [MSUM_W-1:0]      b7_msum_r;
  logic signed [AK_W-1:0] b7_ak_r [D2_LANES];

  logic [D2_LANES-1:0][AKMAG_W-1:0] d2_num;
  logic [D2_LANES-1:0][Q2_W-1:0]    d2_quo;
  d2_side_t d2_in_side, d2_out_side;
  logic     d2_v;

  base_t                 b8_base_r;
  logic signed [C_W-1:0] b8_c_r [D2_LANES];

  out_item_t out_r, out_nxt;

  assign en  = !(out_v_r && out_stall);
  assign pop = en && !fifo_empty;

  always_comb begin
    d1_num[0] = b4_nx_r[N_W-1] ? NMAG_W'(-b4_nx_r) : NMAG_W'(b4_nx_r);
    d1_num[1] = b4_ny_r[N_W-1] ? NMAG_W'(-b4_ny_r) : NMAG_W'(b4_ny_r);
    d1_in_side.base  = b4_pair_r.base;
    d1_in_side.m1    = b4_pair_r.m1;
    d1_in_side.m2    = b4_pair_r.m2;
    d1_in_side.neg_x = b4_nx_r[N_W-1];
    d1_in_side.neg_y = b4_ny_r[N_W-1];
  end

  bpec_div_pipe #(
    .LANES (D1_LANES),
    .NW    (NMAG_W),
    .DW    (D2_W),
    .QW    (Q1_W),
    .SW    ($bits(d1_side_t))
  ) u_div_proj (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (b4_v_r),
    .in_num   (d1_num),
    .in_den   (b4_pair_r.d2),
    .in_side  (d1_in_side),
    .out_v    (d1_v),
    .out_quo  (d1_quo),
    .out_side (d1_out_side)
  );

  // exchange factor of two on the partner's mass
  assign k1 = {b6_m2_r, 1'b0};
  assign k2 = {b6_m1_r, 1'b0};

  always_comb begin
    for (int l = 0; l < D2_LANES; l++) begin
      d2_num[l] = b7_ak_r[l][AK_W-1] ? AKMAG_W'(-b7_ak_r[l]) : AKMAG_W'(b7_ak_r[l]);
      d2_in_side.neg[l] = b7_ak_r[l][AK_W-1];
    end
    d2_in_side.base = b7_base_r;
  end

  bpec_div_pipe #(
    .LANES (D2_LANES),
    .NW    (AKMAG_W),
    .DW    (MSUM_W),
    .QW    (Q2_W),
    .SW    ($bits(d2_side_t))
  ) u_div_mass (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (b7_v_r),
    .in_num   (d2_num),
    .in_den   (b7_msum_r),
    .in_side  (d2_in_side),
    .out_v    (d2_v),
    .out_quo  (d2_quo),
    .out_side (d2_out_side)
  );

  always_comb begin
    out_nxt.collided   = b8_base_r.hit;
    out_nxt.coincident = b8_base_r.same;
    if (b8_base_r.apply) begin
      out_nxt.new_first_vel_x  = sat_vel(SUM_W'(b8_base_r.v1x) - SUM_W'(b8_c_r[0]));
      out_nxt.new_first_vel_y  = sat_vel(SUM_W'(b8_base_r.v1y) - SUM_W'(b8_c_r[1]));
      out_nxt.new_second_vel_x = sat_vel(SUM_W'(b8_base_r.v2x) + SUM_W'(b8_c_r[2]));
      out_nxt.new_second_vel_y = sat_vel(SUM_W'(b8_base_r.v2y) + SUM_W'(b8_c_r[3]));
    end else begin
      out_nxt.new_first_vel_x  = b8_base_r.v1x;
      out_nxt.new_first_vel_y  = b8_base_r.v1y;
      out_nxt.new_second_vel_x = b8_base_r.v2x;
      out_nxt.new_second_vel_y = b8_base_r.v2y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      b3_v_r  <= 1'b0;
      b4_v_r  <= 1'b0;
      b6_v_r  <= 1'b0;
      b7_v_r  <= 1'b0;
      b8_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r  <= pop;
      b2_v_r  <= b1_v_r;
      b3_v_r  <= b2_v_r;
      b4_v_r  <= b3_v_r;
      b6_v_r  <= d1_v;
      b7_v_r  <= b6_v_r;
      b8_v_r  <= d2_v;
      out_v_r <= b8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_pair_r <= head;
      b1_dvx_r  <= DV_W'(head.base.v1x) - DV_W'(head.base.v2x);
      b1_dvy_r  <= DV_W'(head.base.v1y) - DV_W'(head.base.v2y);
      b2_pair_r <= b1_pair_r;
      b2_px_r   <= PP_W'(b1_dvx_r) * PP_W'(b1_pair_r.dx);
      b2_py_r   <= PP_W'(b1_dvy_r) * PP_W'(b1_pair_r.dy);
      b3_pair_r <= b2_pair_r;
      b3_p_r    <= P_W'(b2_px_r) + P_W'(b2_py_r);
      b4_pair_r <= b3_pair_r;
      b4_nx_r   <= N_W'(b3_p_r) * N_W'(b3_pair_r.dx);
      b4_ny_r   <= N_W'(b3_p_r) * N_W'(b3_pair_r.dy);

      b6_base_r <= d1_out_side.base;
      b6_m1_r   <= d1_out_side.m1;
      b6_m2_r   <= d1_out_side.m2;
      b6_msum_r <= MSUM_W'(d1_out_side.m1) + MSUM_W'(d1_out_side.m2);
      b6_ax_r   <= d1_out_side.neg_x ? -$signed(d1_quo[0]) : $signed(d1_quo[0]);
      b6_ay_r   <= d1_out_side.neg_y ? -$signed(d1_quo[1]) : $signed(d1_quo[1]);

      b7_base_r  <= b6_base_r;
      b7_msum_r  <= b6_msum_r;
      b7_ak_r[0] <= AK_W'(b6_ax_r) * AK_W'($signed({1'b0, k1}));
      b7_ak_r[1] <= AK_W'(b6_ay_r) * AK_W'($signed({1'b0, k1}));
      b7_ak_r[2] <= AK_W'(b6_ax_r) * AK_W'($signed({1'b0, k2}));
      b7_ak_r[3] <= AK_W'(b6_ay_r) * AK_W'($signed({1'b0, k2}));

      b8_base_r <= d2_out_side.base;
      for (int l = 0; l < D2_LANES; l++) begin
        b8_c_r[l] <= d2_out_side.neg[l] ? -$signed({1'b0, d2_quo[l]})
                                        : $signed({1'b0, d2_quo[l]});
      end

      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

### src/ball_pair_elastic_collision_core.sv
// top level of the two-body elastic collision core
// depends on bpec_pkg, bpec_front, bpec_fifo, bpec_back and the macros header
//
// One pair of circular bodies goes in per transaction on in_valid/in_stall with
// in_data; one result comes out per pair on out_valid/out_stall with out_data,
// in the order the pairs came in. A transaction completes on a rising edge with
// valid high and stall low.
// Throughput: one pair per cycle unless out_stall or a full queue holds the
// flow. Every stage is a register stage, including the two divides, which
// retire one quotient bit per stage. A pair passes through, in order, 3 front
// stages, the queue, 4 projection stages, 35 divide stages, 2 mass stages, 35
// divide stages, 1 rescale stage and the output register.
// A stall on out_stall while out_valid is high freezes the back end and holds
// out_data; the queue keeps filling from the front, and in_stall rises once the
// queue is full and the last front stage holds a pair.
// Synchronous reset on rst_n (active low) empties the queue and drops all
// in-flight transactions; no clearing pass is needed.
`include "ball_pair_elastic_collision_core_macros.svh"
module ball_pair_elastic_collision_core import bpec_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic  push_v, fifo_full, fifo_empty, pop;
  pair_t push_item, head;

  bpec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push_v    (push_v),
    .push_item (push_item),
    .fifo_full (fifo_full)
  );

  bpec_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_v),
    .push_item (push_item),
    .full      (fifo_full),
    .pop       (pop),
    .head      (head),
    .empty     (fifo_empty)
  );

  bpec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // coincident centres only ever come with an overlap
  `BPEC_ASSERT_IMPL(a_coinc_hit, out_valid && out_data.coincident, out_data.collided)
  // a full queue stays full until the back end drains it
  `BPEC_ASSERT_NEXT(a_full_hold, fifo_full && !pop, fifo_full)
  // a pop always leaves room for the front
  `BPEC_ASSERT_NEXT(a_pop_frees, pop, !fifo_full)

endmodule

### dv/ball_pair_elastic_collision_core_test.sv
// self-checking testbench for the two-body elastic collision core
// depends on bpec_pkg and the core; predicts each result in plain integer terms
module ball_pair_elastic_collision_core_test import bpec_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // holds predicted collision results in arrival order and checks the outputs
  class collision_scoreboard;
    out_item_t predicted_q[$];
    int        mismatches;

    function automatic longint clamp_vel(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note_pair(in_item_t p);
      out_item_t r;
      longint    dx, dy, d2, rs, v1x, v1y, v2x, v2y, m1, m2, msum;
      logic signed [127:0] proj, ax, ay;
      logic signed [127:0] d2w, msw;
      logic      hit, same;
      dx  = longint'(p.first_pos_x) - longint'(p.second_pos_x);
      dy  = longint'(p.first_pos_y) - longint'(p.second_pos_y);
      d2  = dx * dx + dy * dy;
      rs  = longint'(p.first_radius) + longint'(p.second_radius);
      hit = (rs * rs) > d2;
      same = hit && d2 == 0;
      v1x = longint'(p.first_vel_x);  v1y = longint'(p.first_vel_y);
      v2x = longint'(p.second_vel_x); v2y = longint'(p.second_vel_y);
      m1  = longint'(p.first_mass);   m2 = longint'(p.second_mass);
      msum = m1 + m2;
      r.collided   = hit;
      r.coincident = same;
      r.new_first_vel_x  = 32'(v1x); r.new_first_vel_y  = 32'(v1y);
      r.new_second_vel_x = 32'(v2x); r.new_second_vel_y = 32'(v2y);
      if (hit && !same && msum != 0) begin
        // 128-bit signed arithmetic; division truncates toward zero
        d2w  = 128'(d2);
        msw  = 128'(msum);
        proj = 128'(v1x - v2x) * 128'(dx) + 128'(v1y - v2y) * 128'(dy);
        ax   = (proj * 128'(dx)) / d2w;
        ay   = (proj * 128'(dy)) / d2w;
        r.new_first_vel_x  = 32'(clamp_vel(v1x - longint'((ax * 128'(2 * m2)) / msw)));
        r.new_first_vel_y  = 32'(clamp_vel(v1y - longint'((ay * 128'(2 * m2)) / msw)));
        r.new_second_vel_x = 32'(clamp_vel(v2x + longint'((ax * 128'(2 * m1)) / msw)));
        r.new_second_vel_y = 32'(clamp_vel(v2y + longint'((ay * 128'(2 * m1)) / msw)));
      end
      predicted_q = {predicted_q, r};
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (predicted_q.size() == 0) begin
        report(got, got, 1'b1);
        return;
      end
      exp_r = predicted_q.pop_front();
      if (got !== exp_r) report(exp_r, got, 1'b0);
    endfunction

    function void report(out_item_t exp_r, out_item_t got, logic unexpected);
      mismatches++;
      if (mismatches <= 10) begin
        if (unexpected)
          $display("unexpected result %p", got);
        else
          $display("mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  collision_scoreboard board = new();

  ball_pair_elastic_collision_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic signed [31:0] pick_vel();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 2097151)) - 32'sd1048576;
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t random_pair();
    in_item_t p;
    int spread;
    p.first_pos_x = 12'($urandom());
    p.first_pos_y = 12'($urandom());
    // mostly near neighbours so that overlaps are common
    spread = ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(0, 40);
    p.second_pos_x = 12'(p.first_pos_x + $urandom_range(0, 2 * spread) - spread);
    p.second_pos_y = 12'(p.first_pos_y + $urandom_range(0, 2 * spread) - spread);
    if ($urandom_range(0, 19) == 0) begin
      p.second_pos_x = p.first_pos_x;
      p.second_pos_y = p.first_pos_y;
    end
    p.first_vel_x  = pick_vel();
    p.first_vel_y  = pick_vel();
    p.second_vel_x = pick_vel();
    p.second_vel_y = pick_vel();
    p.first_mass   = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom());
    p.second_mass  = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom());
    p.first_radius  = ($urandom_range(0, 3) == 0) ? 10'($urandom())
                                                  : 10'($urandom_range(0, 40));
    p.second_radius = ($urandom_range(0, 3) == 0) ? 10'($urandom())
                                                  : 10'($urandom_range(0, 40));
    return p;
  endfunction

  // presents one pair and waits for its transaction
  task automatic send_pair(in_item_t p);
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    board.note_pair(p);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic run_directed();
    in_item_t p;
    p = '0;
    send_pair(p);                       // zero radii, coincident: no overlap
    p.first_radius = 10'd1;
    send_pair(p);                       // coincident centres
    p = '0;
    p.first_pos_x = 12'd4095; p.first_pos_y = 12'd4095;
    p.first_radius = 10'd1023; p.second_radius = 10'd1023;
    p.first_vel_x = 32'sh7fffffff; p.second_vel_x = 32'sh80000000;
    p.first_vel_y = 32'sh80000000; p.second_vel_y = 32'sh7fffffff;
    p.first_mass = 16'hffff; p.second_mass = 16'hffff;
    send_pair(p);                       // far apart on diagonal, largest radii, still no overlap
    p.first_mass = 16'd0; p.second_mass = 16'd0;
    send_pair(p);                       // both massless
    p.first_mass = 16'd0; p.second_mass = 16'hffff;
    send_pair(p);
    p.first_mass = 16'hffff; p.second_mass = 16'd0;
    send_pair(p);
    p.first_radius = 10'd1; p.second_radius = 10'd1;
    send_pair(p);                       // far apart: no overlap
    p = '0;
    p.second_pos_x = 12'd4095; p.first_radius = 10'd1023; p.second_radius = 10'd1023;
    p.first_vel_x = 32'sh00010000; p.first_mass = 16'h0100; p.second_mass = 16'h0100;
    send_pair(p);                       // distance well beyond the radius sum: no overlap
    p.second_pos_x = 12'd3; p.first_radius = 10'd2; p.second_radius = 10'd1;
    send_pair(p);                       // touching, not overlapping
    p.second_pos_x = 12'd2;
    send_pair(p);                       // equal masses head-on
    p.second_pos_y = 12'd5; p.second_pos_x = 12'd0; p.first_radius = 10'd9;
    p.second_vel_y = 32'sh80000000;
    send_pair(p);
    for (int i = 0; i < 8; i++) begin
      p = random_pair();
      p.first_vel_x = (i[0]) ? 32'sh7fffffff : 32'sh80000000;
      p.second_vel_x = ~p.first_vel_x;
      p.second_pos_x = p.first_pos_x; p.second_pos_y = p.first_pos_y + 12'd1;
      p.first_radius = 10'd2;
      send_pair(p);
    end
    idle_cycles(1);
  endtask

  task automatic run_random(int count);
    int burst;
    while (count > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int i = 0; i < burst && count > 0; i++) begin
        send_pair(random_pair());
        count--;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
    end
    in_valid <= 1'b0;
  endtask

  // receiver stall pattern, with one long hold-off early on
  initial begin
    int mode;
    out_stall = 1'b0;
    @(posedge rst_n);
    repeat (60) @(posedge clk);
    out_stall <= 1'b1;
    repeat (300) @(posedge clk);
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 80)) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(1030);
    while (board.predicted_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.mismatches == 0 && board.predicted_q.size() == 0)
      $display("** ball_pair_elastic_collision_core: PASSED **");
    else
      $display("** ball_pair_elastic_collision_core: FAILED **");
    $finish;
  end

  initial begin
    #400000;
    $display("** ball_pair_elastic_collision_core: FAILED **");
    $finish;
  end

endmodule
